>>> src/cp1251_to_utf8_converter_assert.svh
// Assertion macros shared by the converter's checker
`ifndef CP1251_TO_UTF8_CONVERTER_ASSERT_SVH
`define CP1251_TO_UTF8_CONVERTER_ASSERT_SVH

// Same-cycle implication, off during reset
`define C2U_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset
`define C2U_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also covers reset
`define C2U_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/c2u_pkg.sv
// Shared types and constants of the CP1251 to UTF-8 converter
`timescale 1ns / 1ps
package c2u_pkg;

  // Widths
  localparam int BYTE_W   = 8;
  localparam int CP_W     = 14;
  localparam int MAX_UTF  = 3;
  localparam int NB_W     = 2;

  // Encoded byte counts
  localparam logic [NB_W-1:0] NB_ONE   = 2'd1;
  localparam logic [NB_W-1:0] NB_TWO   = 2'd2;
  localparam logic [NB_W-1:0] NB_THREE = 2'd3;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One encoded character: byte 0 goes out first
  typedef struct packed {
    logic [NB_W-1:0]                 nbytes;
    logic [MAX_UTF-1:0][BYTE_W-1:0]  bytes;
  } c2u_enc_t;

endpackage

>>> src/c2u_front.sv
// Front end: accepts CP1251 bytes, maps them and builds the UTF-8 bytes
`timescale 1ns / 1ps
module c2u_front import c2u_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              enc_valid,
  input  logic              enc_ready,
  output c2u_enc_t          enc_data
);

  // Code point of one CP1251 byte
  function automatic logic [CP_W-1:0] cp_lookup(input logic [BYTE_W-1:0] b);
    logic [CP_W-1:0] cp;
    unique case (b)
      8'h80: cp = 14'd1026;  8'h81: cp = 14'd1027;  8'h82: cp = 14'd8218;
      8'h83: cp = 14'd1107;  8'h84: cp = 14'd8222;  8'h85: cp = 14'd8230;
      8'h86: cp = 14'd8224;  8'h87: cp = 14'd8225;  8'h88: cp = 14'd8364;
      8'h89: cp = 14'd8240;  8'h8a: cp = 14'd1033;  8'h8b: cp = 14'd8249;
      8'h8c: cp = 14'd1034;  8'h8d: cp = 14'd1036;  8'h8e: cp = 14'd1035;
      8'h8f: cp = 14'd1039;
      8'h90: cp = 14'd1106;  8'h91: cp = 14'd8216;  8'h92: cp = 14'd8217;
      8'h93: cp = 14'd8220;  8'h94: cp = 14'd8221;  8'h95: cp = 14'd8226;
      8'h96: cp = 14'd8211;  8'h97: cp = 14'd8212;
      // unassigned position, mapped like 0x9B
      8'h98: cp = 14'd8250;
      8'h99: cp = 14'd8482;  8'h9a: cp = 14'd1113;  8'h9b: cp = 14'd8250;
      8'h9c: cp = 14'd1114;  8'h9d: cp = 14'd1116;  8'h9e: cp = 14'd1115;
      8'h9f: cp = 14'd1119;
      8'ha0: cp = 14'd160;   8'ha1: cp = 14'd1038;  8'ha2: cp = 14'd1118;
      8'ha3: cp = 14'd1032;  8'ha4: cp = 14'd164;   8'ha5: cp = 14'd1168;
      8'ha6: cp = 14'd166;   8'ha7: cp = 14'd167;   8'ha8: cp = 14'd1025;
      8'ha9: cp = 14'd169;   8'haa: cp = 14'd1028;  8'hab: cp = 14'd171;
      8'hac: cp = 14'd172;   8'had: cp = 14'd173;   8'hae: cp = 14'd174;
      8'haf: cp = 14'd1031;
      8'hb0: cp = 14'd176;   8'hb1: cp = 14'd177;   8'hb2: cp = 14'd1030;
      8'hb3: cp = 14'd1110;  8'hb4: cp = 14'd1169;  8'hb5: cp = 14'd181;
      8'hb6: cp = 14'd182;   8'hb7: cp = 14'd183;   8'hb8: cp = 14'd1105;
      8'hb9: cp = 14'd8470;  8'hba: cp = 14'd1108;  8'hbb: cp = 14'd187;
      8'hbc: cp = 14'd1112;  8'hbd: cp = 14'd1029;  8'hbe: cp = 14'd1109;
      8'hbf: cp = 14'd1111;
      default: begin
        // ASCII passes through, 0xC0 and up is the contiguous Cyrillic block
        if (b[7] == 1'b0) cp = {{(CP_W-BYTE_W){1'b0}}, b};
        else cp = 14'd848 + {{(CP_W-BYTE_W){1'b0}}, b};
      end
    endcase
    return cp;
  endfunction

  // UTF-8 bytes of one code point
  function automatic c2u_enc_t utf8_encode(input logic [CP_W-1:0] cp);
    c2u_enc_t e;
    e = '0;
    if (cp < 14'h0080) begin
      e.nbytes   = NB_ONE;
      e.bytes[0] = cp[7:0];
    end else if (cp < 14'h0800) begin
      e.nbytes   = NB_TWO;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      e.nbytes   = NB_THREE;
      e.bytes[0] = {4'b1110, 2'b00, cp[13:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  logic     stage_valid_r, stage_valid_nxt;
  c2u_enc_t stage_enc_r, stage_enc_nxt;
  logic     stage_ready;

  assign stage_ready = !stage_valid_r || enc_ready;
  assign full        = !stage_ready;

  // Load a new character whenever the stage drains or is empty
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    stage_enc_nxt   = stage_enc_r;
    if (stage_ready) begin
      stage_valid_nxt = push;
      stage_enc_nxt   = utf8_encode(cp_lookup(in_byte));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_enc_r <= stage_enc_nxt;
  end

  assign enc_valid = stage_valid_r;
  assign enc_data  = stage_enc_r;

endmodule

>>> src/c2u_queue.sv
// Short queue of encoded characters between front and back
`timescale 1ns / 1ps
module c2u_queue import c2u_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  c2u_enc_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output c2u_enc_t rd_data
);

  c2u_enc_t             mem_r [Q_DEPTH];
  logic [Q_IDX_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_IDX_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_wr, do_rd;

  assign wr_ready = (count_r != Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) count_nxt = count_r + 1'b1;
    else if (do_rd && !do_wr) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming character
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

>>> src/c2u_back.sv
// Back end: serializes encoded characters into the output byte register
`timescale 1ns / 1ps
module c2u_back import c2u_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              enc_valid,
  output logic              enc_ready,
  input  c2u_enc_t          enc_data,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_byte
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic [NB_W-1:0]   idx_r, idx_nxt;
  logic              out_xfer, can_load, is_last;

  assign out_xfer = pop && out_valid_r;
  assign can_load = !out_valid_r || out_xfer;
  assign is_last  = ((idx_r + 1'b1) == enc_data.nbytes);
  assign enc_ready = can_load && is_last;

  // Send the next byte of the head character, drop it after its last byte
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    idx_nxt       = idx_r;
    if (can_load) begin
      out_valid_nxt = enc_valid;
      if (enc_valid) begin
        out_byte_nxt = enc_data.bytes[idx_r];
        out_last_nxt = is_last;
        idx_nxt      = is_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign empty         = !out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

>>> src/cp1251_to_utf8_converter.sv
// Top level of the CP1251 to UTF-8 converter
// Converts one Windows-1251 byte per transfer into its UTF-8 bytes, one byte per
// result transfer, with out_last_byte marking the final byte of each character.
// Byte 0 gives a single 0 byte; 0x98 encodes as U+203A. The output byte register
// delivers one byte per cycle while pop is held, and an input byte yields 1, 2 or 3
// output bytes according to its UTF-8 length; push may continue every cycle while the
// two-entry queue has room. The first result byte of an input is registered in the
// front stage, then in the queue and then in the output register.
`timescale 1ns / 1ps
module cp1251_to_utf8_converter import c2u_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_byte
);

  logic     f_valid, f_ready;
  c2u_enc_t f_data;
  logic     b_valid, b_ready;
  c2u_enc_t b_data;

  c2u_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .enc_valid (f_valid),
    .enc_ready (f_ready),
    .enc_data  (f_data)
  );

  c2u_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  c2u_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .enc_valid     (b_valid),
    .enc_ready     (b_ready),
    .enc_data      (b_data),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule

>>> src/c2u_checker.sv
// Port-level checker of the converter, bound to the top level
`timescale 1ns / 1ps
`include "cp1251_to_utf8_converter_assert.svh"
module c2u_checker import c2u_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              push,
  input logic              full,
  input logic [BYTE_W-1:0] in_byte,
  input logic              empty,
  input logic              pop,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last_byte
);

  logic in_seen;
  assign in_seen = push || full || (in_byte == '0) || (in_byte != '0);

  // Reset leaves no result waiting
  `C2U_ASSERT_RST(a_reset_empty, clk, !rst_n, empty)

  // A stalled result holds
  `C2U_ASSERT_NXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last_byte))

  // ASCII bytes always end a character
  `C2U_ASSERT_IMP(a_ascii_last, clk, rst_n, in_seen && !empty && !out_byte[7], out_last_byte)

  // Lead bytes never end a character
  `C2U_ASSERT_IMP(a_lead_not_last, clk, rst_n, !empty && out_byte[7:6] == 2'b11, !out_last_byte)

endmodule

bind cp1251_to_utf8_converter c2u_checker u_chk (.*);
